[design/prrd_pkg.sv]
// shared constants and types of the priority round-robin dispatcher
package prrd_pkg;

    localparam int SLOT_COUNT  = 64;
    localparam int LEVEL_COUNT = 7;
    localparam int SLOT_W      = $clog2(SLOT_COUNT);
    localparam int LVL_W       = $clog2(LEVEL_COUNT);
    localparam int KIND_W      = 2;
    localparam int LEVEL_W     = 3;
    localparam int TIME_W      = 32;
    localparam int DATA_W      = 32;
    localparam int PADDR_W     = 3;

    localparam logic [TIME_W-1:0]  SLICE_RESET       = 32'd80;
    localparam logic [PADDR_W-1:0] ADDR_SLICE_LENGTH = 3'd0;

    localparam logic [KIND_W-1:0] KIND_READY  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVENT,
        ST_DISPATCH,
        ST_ROTATE,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic capture;
        logic link_rd;
        logic do_event;
        logic do_dispatch;
        logic do_rotate;
    } t_cmd;

    typedef struct packed {
        logic skip;
        logic preempt;
    } t_status;

endpackage

[design/prrd_cfg.sv]
// configuration register block with its bus port
module prrd_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [prrd_pkg::PADDR_W-1:0]  paddr,
    input  logic [prrd_pkg::DATA_W-1:0]   pwdata,
    output logic [prrd_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output logic [prrd_pkg::TIME_W-1:0]   o_slice_length
);
    import prrd_pkg::*;

    logic [TIME_W-1:0] r_slice_length;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slice_length <= SLICE_RESET;
        end else if (wr_en && paddr == ADDR_SLICE_LENGTH) begin
            r_slice_length <= pwdata;
        end
    end

    always_comb begin
        unique case (paddr)
            ADDR_SLICE_LENGTH: prdata = r_slice_length;
            default:           prdata = '0;
        endcase
    end

    assign o_slice_length = r_slice_length;

endmodule

[design/prrd_ctrl.sv]
// sequencer for one event: capture, apply, dispatch unless skipped, optional rotate, result beat
module prrd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_stall,
    input  prrd_pkg::t_status i_status,
    output prrd_pkg::t_cmd    o_cmd,
    output logic              o_stall,
    output logic              o_valid
);
    import prrd_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) n_state = ST_EVENT;
            end
            ST_EVENT: begin
                n_state = i_status.skip ? ST_OUT : ST_DISPATCH;
            end
            ST_DISPATCH: begin
                n_state = i_status.preempt ? ST_ROTATE : ST_OUT;
            end
            ST_ROTATE: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!i_stall) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        o_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_stall       = !i_rst_n;
                o_cmd.capture = i_valid && i_rst_n;
                o_cmd.link_rd = 1'b1;
            end
            ST_EVENT:    o_cmd.do_event    = 1'b1;
            ST_DISPATCH: o_cmd.do_dispatch = 1'b1;
            ST_ROTATE:   o_cmd.do_rotate   = 1'b1;
            ST_OUT:      o_valid           = 1'b1;
            default: ;
        endcase
    end

`ifndef SYNTH
    a_rotate_follows_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_ROTATE |-> $past(r_state) == ST_DISPATCH)
        else $error("rotate step without a preceding dispatch");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_OUT && i_stall |=> r_state == ST_OUT)
        else $error("result beat dropped while stalled");
`endif

endmodule

[design/prrd_datapath.sv]
// ready queues, link memory, running task and slice timer
module prrd_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  prrd_pkg::t_cmd                i_cmd,
    output prrd_pkg::t_status             o_status,
    input  logic [prrd_pkg::KIND_W-1:0]   i_kind,
    input  logic [prrd_pkg::SLOT_W-1:0]   i_slot,
    input  logic [prrd_pkg::LEVEL_W-1:0]  i_level,
    input  logic [prrd_pkg::TIME_W-1:0]   i_now,
    input  logic [prrd_pkg::TIME_W-1:0]   i_slice_length,
    output logic [prrd_pkg::SLOT_W-1:0]   o_running_slot,
    output logic                          o_running_valid,
    output logic                          o_switched,
    output logic                          o_rejected
);
    import prrd_pkg::*;

    // captured item
    logic [KIND_W-1:0]  r_kind;
    logic [SLOT_W-1:0]  r_slot;
    logic [LEVEL_W-1:0] r_level;
    logic [TIME_W-1:0]  r_now;

    // queue table, one level per cycle goes through lvl_sel
    logic [LEVEL_COUNT-1:0] r_head_valid;
    logic [SLOT_W-1:0]      r_head_slot [LEVEL_COUNT];
    logic [SLOT_W-1:0]      r_tail      [LEVEL_COUNT];
    logic [SLOT_COUNT-1:0]  r_queued;
    logic [SLOT_W-1:0]      r_link_mem  [SLOT_COUNT];
    logic [SLOT_W-1:0]      r_link;

    logic              r_cur_valid;
    logic [SLOT_W-1:0] r_cur_slot;
    logic [LVL_W-1:0]  r_cur_lvl;
    logic [TIME_W-1:0] r_slice_start;
    logic [SLOT_W-1:0] r_prev_slot;
    logic [LVL_W-1:0]  r_prev_lvl;
    logic              r_switched;
    logic              r_rejected;
    logic              r_force;

    logic [LVL_W-1:0]  push_lvl;
    logic [LVL_W-1:0]  pick_lvl;
    logic [LVL_W-1:0]  lvl_sel;
    logic              any_ready;
    logic [SLOT_W-1:0] sel_head;
    logic [SLOT_W-1:0] sel_tail;
    logic              sel_hv;
    logic [SLOT_W-1:0] rot_slot;
    logic              rot_en;
    logic [TIME_W-1:0] elapsed;
    logic              expired;
    logic              ev_reject;
    logic              ev_skip;
    logic              same_task;
    logic              preempt;

    logic              head_we;
    logic              head_wv;
    logic [SLOT_W-1:0] head_wslot;
    logic              tail_we;
    logic [SLOT_W-1:0] tail_wslot;
    logic              link_we;
    logic [SLOT_W-1:0] link_addr;
    logic [SLOT_W-1:0] link_data;
    logic              q_set;
    logic              q_clr;
    logic [SLOT_W-1:0] q_addr;

    // level 0 counts as the top level, anything past the last as the last
    always_comb begin
        if (r_level == '0) begin
            push_lvl = '0;
        end else if (32'(r_level) > LEVEL_COUNT) begin
            push_lvl = LVL_W'(LEVEL_COUNT - 1);
        end else begin
            push_lvl = LVL_W'(r_level - 1'b1);
        end
    end

    always_comb begin
        pick_lvl = '0;
        for (int i = LEVEL_COUNT - 1; i >= 0; i--) begin
            if (r_head_valid[i]) pick_lvl = LVL_W'(i);
        end
    end

    assign any_ready = |r_head_valid;

    always_comb begin
        if (i_cmd.do_dispatch) begin
            lvl_sel = pick_lvl;
        end else if (i_cmd.do_rotate) begin
            lvl_sel = r_prev_lvl;
        end else if (r_kind == KIND_READY) begin
            lvl_sel = push_lvl;
        end else begin
            lvl_sel = r_cur_lvl;
        end
    end

    assign sel_head = r_head_slot[lvl_sel];
    assign sel_tail = r_tail[lvl_sel];
    assign sel_hv   = r_head_valid[lvl_sel];

    assign elapsed = r_now - r_slice_start;
    assign expired = elapsed >= i_slice_length;

    always_comb begin
        case (r_kind)
            KIND_READY:  ev_reject = r_queued[r_slot];
            KIND_REMOVE: ev_reject = !r_cur_valid;
            default:     ev_reject = 1'b0;
        endcase
        case (r_kind) inside
            KIND_READY, KIND_REMOVE: ev_skip = ev_reject;
            KIND_TICK:               ev_skip = 1'b0;
            default:                 ev_skip = 1'b1;
        endcase
    end

    assign same_task = r_cur_valid && (sel_head == r_cur_slot);
    assign preempt   = any_ready && r_cur_valid && !same_task && (pick_lvl < r_cur_lvl);

    assign o_status.skip    = ev_skip;
    assign o_status.preempt = preempt;

    assign rot_slot = i_cmd.do_rotate ? r_prev_slot : r_cur_slot;
    assign rot_en   = i_cmd.do_rotate
                   || (i_cmd.do_event && r_kind == KIND_TICK && r_cur_valid && expired);

    // one write per table per cycle; the link of a tail is never read, so it is not cleared
    always_comb begin
        head_we    = 1'b0;
        head_wv    = 1'b1;
        head_wslot = r_link;
        tail_we    = 1'b0;
        tail_wslot = rot_slot;
        link_we    = 1'b0;
        link_addr  = sel_tail;
        link_data  = rot_slot;
        q_set      = 1'b0;
        q_clr      = 1'b0;
        q_addr     = r_slot;
        // a lone task rotated onto itself leaves the level as it was
        if (rot_en && rot_slot != sel_tail) begin
            head_we = 1'b1;
            link_we = 1'b1;
            tail_we = 1'b1;
        end
        if (i_cmd.do_event && !ev_reject) begin
            case (r_kind)
                KIND_READY: begin
                    link_we    = sel_hv;
                    link_data  = r_slot;
                    tail_we    = 1'b1;
                    tail_wslot = r_slot;
                    q_set      = 1'b1;
                    if (!sel_hv) begin
                        head_we    = 1'b1;
                        head_wslot = r_slot;
                    end
                end
                KIND_REMOVE: begin
                    q_clr   = 1'b1;
                    q_addr  = r_cur_slot;
                    head_we = 1'b1;
                    head_wv = (r_cur_slot != sel_tail);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid  <= '0;
            for (int i = 0; i < LEVEL_COUNT; i++) begin
                r_tail[i] <= '0;
            end
            r_queued      <= '0;
            r_cur_valid   <= 1'b0;
            r_cur_slot    <= '0;
            r_slice_start <= '0;
            r_switched    <= 1'b0;
            r_rejected    <= 1'b0;
            r_force       <= 1'b0;
        end else begin
            if (head_we) r_head_valid[lvl_sel] <= head_wv;
            if (tail_we) r_tail[lvl_sel] <= tail_wslot;
            if (q_set) r_queued[q_addr] <= 1'b1;
            if (q_clr) r_queued[q_addr] <= 1'b0;
            if (i_cmd.capture) begin
                r_switched <= 1'b0;
                r_rejected <= 1'b0;
                r_force    <= 1'b0;
            end
            if (i_cmd.do_event) begin
                r_rejected <= ev_reject;
                if (r_kind == KIND_REMOVE && !ev_reject) begin
                    r_force     <= 1'b1;
                    r_cur_valid <= 1'b0;
                    r_cur_slot  <= '0;
                end
            end
            if (i_cmd.do_dispatch) begin
                if (!any_ready) begin
                    r_cur_valid <= 1'b0;
                    r_cur_slot  <= '0;
                    r_switched  <= r_force | r_cur_valid;
                end else if (same_task) begin
                    r_switched <= r_force;
                end else begin
                    r_cur_valid   <= 1'b1;
                    r_cur_slot    <= sel_head;
                    r_slice_start <= r_now;
                    r_switched    <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind  <= i_kind;
            r_slot  <= i_slot;
            r_level <= i_level;
            r_now   <= i_now;
        end
        if (i_cmd.link_rd) r_link <= r_link_mem[r_cur_slot];
        if (link_we) r_link_mem[link_addr] <= link_data;
        if (head_we) r_head_slot[lvl_sel] <= head_wslot;
        if (i_cmd.do_dispatch && any_ready && !same_task) begin
            r_prev_slot <= r_cur_slot;
            r_prev_lvl  <= r_cur_lvl;
            r_cur_lvl   <= pick_lvl;
        end
    end

    assign o_running_slot  = r_cur_slot;
    assign o_running_valid = r_cur_valid;
    assign o_switched      = r_switched;
    assign o_rejected      = r_rejected;

`ifndef SYNTH
    a_running_is_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_valid |-> r_queued[r_cur_slot])
        else $error("running task not marked queued");

    a_running_level_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_valid |-> r_head_valid[r_cur_lvl])
        else $error("running task's level is empty");

    a_preempt_higher: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.do_dispatch && preempt |=> r_cur_lvl < r_prev_lvl)
        else $error("preemption by a level that is not higher");

    a_ready_marks_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.do_event && r_kind == KIND_READY && !ev_reject |=> r_queued[$past(r_slot)])
        else $error("accepted ready request left slot unqueued");
`endif

endmodule

[design/priority_round_robin_dispatcher_top.sv]
// top level of the priority round-robin dispatcher
// Seven FIFO ready queues (level 1 highest) over 64 task slots; each event beat
// (make ready, remove running, tick) returns one result beat with the running slot,
// a switch flag and a reject flag. Items are handled one at a time: a beat is taken
// in the idle state, then the event is applied, a dispatch to the head of the
// highest non-empty level follows unless the event is rejected or of the unused kind,
// and a preemption adds a rotate step to requeue the old task; the result beat follows
// and is held while the output stalls, and the next item is taken in the cycle after
// the result leaves. This one-at-a-time handling is set by the single-ported slot
// link memory and the queue table, which is touched at one level per cycle.
// slice_length sits at byte address 0 of the bus port and resets to 80.
module priority_round_robin_dispatcher_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [prrd_pkg::KIND_W-1:0]   i_kind,
    input  logic [prrd_pkg::SLOT_W-1:0]   i_slot,
    input  logic [prrd_pkg::LEVEL_W-1:0]  i_level,
    input  logic [prrd_pkg::TIME_W-1:0]   i_now,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [prrd_pkg::SLOT_W-1:0]   o_running_slot,
    output logic                          o_running_valid,
    output logic                          o_switched,
    output logic                          o_rejected,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [prrd_pkg::PADDR_W-1:0]  paddr,
    input  logic [prrd_pkg::DATA_W-1:0]   pwdata,
    output logic [prrd_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import prrd_pkg::*;

    t_cmd              cmd;
    t_status           status;
    logic [TIME_W-1:0] slice_length;

    prrd_cfg u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_slice_length (slice_length)
    );

    prrd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_stall  (i_stall),
        .i_status (status),
        .o_cmd    (cmd),
        .o_stall  (o_stall),
        .o_valid  (o_valid)
    );

    prrd_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_kind          (i_kind),
        .i_slot          (i_slot),
        .i_level         (i_level),
        .i_now           (i_now),
        .i_slice_length  (slice_length),
        .o_running_slot  (o_running_slot),
        .o_running_valid (o_running_valid),
        .o_switched      (o_switched),
        .o_rejected      (o_rejected)
    );

endmodule
